// ===== src/apc_pkg.sv =====
`default_nettype none

package apc_pkg;

  // Character buffer geometry.
  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

  // Fixed widths of the beat fields.
  localparam int CHAR_W = 8;
  localparam int KEPT_W = 9;

  // ASCII code points used by the classifier.
  localparam logic [CHAR_W-1:0] CODE_DIGIT_LO = 8'h30;
  localparam logic [CHAR_W-1:0] CODE_DIGIT_HI = 8'h39;
  localparam logic [CHAR_W-1:0] CODE_UPPER_LO = 8'h41;
  localparam logic [CHAR_W-1:0] CODE_UPPER_HI = 8'h5A;
  localparam logic [CHAR_W-1:0] CODE_LOWER_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CODE_LOWER_HI = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

  // Controller states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_COMPARE,
    ST_REPORT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take one input byte
    logic sweep;  // run the pairwise compare
    logic clear;  // drop the string after its result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;
  } dp_status_t;

  // True for ASCII letters and digits.
  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return ((c >= CODE_DIGIT_LO) && (c <= CODE_DIGIT_HI)) ||
           ((c >= CODE_UPPER_LO) && (c <= CODE_UPPER_HI)) ||
           ((c >= CODE_LOWER_LO) && (c <= CODE_LOWER_HI));
  endfunction

  // Fold an upper-case letter to lower case; other codes pass unchanged.
  function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
    if ((c >= CODE_UPPER_LO) && (c <= CODE_UPPER_HI)) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/apc_ctrl.sv =====
`default_nettype none

module apc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               last_char,
  input  wire apc_pkg::dp_status_t status,
  output apc_pkg::dp_cmd_t         cmd,
  output logic                     busy,
  output logic                     done
);

  apc_pkg::state_t state;
  apc_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apc_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      apc_pkg::ST_LOAD: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start && last_char) begin
          state_next = apc_pkg::ST_COMPARE;
        end
      end
      apc_pkg::ST_COMPARE: begin
        cmd.sweep = 1'b1;
        if (status.sweep_done) begin
          state_next = apc_pkg::ST_REPORT;
        end
      end
      apc_pkg::ST_REPORT: begin
        done       = 1'b1;
        cmd.clear  = 1'b1;
        state_next = apc_pkg::ST_LOAD;
      end
      default: begin
        state_next = apc_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/apc_datapath.sv =====
`default_nettype none

module apc_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire apc_pkg::dp_cmd_t            cmd,
  input  wire logic [apc_pkg::CHAR_W-1:0]  char_code,
  output apc_pkg::dp_status_t              status,
  output logic                             is_palindrome,
  output logic [apc_pkg::KEPT_W-1:0]       kept_length,
  output logic                             overflow
);

  localparam logic [apc_pkg::CNT_W-1:0] DEPTH_CNT = apc_pkg::CNT_W'(apc_pkg::BUFFER_DEPTH);

  logic [apc_pkg::CHAR_W-1:0] char_store [apc_pkg::BUFFER_DEPTH];

  logic [apc_pkg::CNT_W-1:0]  kept_count;
  logic                       overflow_seen;
  logic [apc_pkg::ADDR_W-1:0] front_idx;
  logic                       pair_pending;
  logic                       mismatch;
  logic [apc_pkg::CHAR_W-1:0] front_char;
  logic [apc_pkg::CHAR_W-1:0] back_char;

  logic                       keep_byte;
  logic                       has_room;
  logic [apc_pkg::CNT_W-1:0]  half_count;
  logic [apc_pkg::CNT_W-1:0]  back_pos;
  logic                       pair_left;
  logic                       issue_read;

  // Classify the incoming byte and check room in the buffer.
  assign keep_byte = cmd.load && apc_pkg::is_alnum(char_code);
  assign has_room  = kept_count < DEPTH_CNT;

  // Pair addresses: front index walks up, back index is its mirror.
  assign half_count = kept_count >> 1;
  assign back_pos   = kept_count - apc_pkg::CNT_W'(1) - apc_pkg::CNT_W'(front_idx);
  assign pair_left  = apc_pkg::CNT_W'(front_idx) < half_count;
  assign issue_read = cmd.sweep && !overflow_seen && pair_left;

  // The sweep ends once every pair is issued; the last pair compares on the same edge.
  assign status.sweep_done = overflow_seen || !pair_left;

  // Character buffer: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (keep_byte && has_room) begin
      char_store[kept_count[apc_pkg::ADDR_W-1:0]] <= apc_pkg::fold_lower(char_code);
    end
    if (issue_read) begin
      front_char <= char_store[front_idx];
      back_char  <= char_store[back_pos[apc_pkg::ADDR_W-1:0]];
    end
  end

  // Count, overflow and compare state.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      kept_count    <= '0;
      overflow_seen <= 1'b0;
      front_idx     <= '0;
      pair_pending  <= 1'b0;
      mismatch      <= 1'b0;
    end else begin
      if (keep_byte) begin
        if (has_room) begin
          kept_count <= kept_count + apc_pkg::CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (issue_read) begin
        front_idx <= front_idx + apc_pkg::ADDR_W'(1);
      end
      pair_pending <= issue_read;
      if (pair_pending && (front_char != back_char)) begin
        mismatch <= 1'b1;
      end
    end
  end

  // Result fields, valid while the controller reports.
  assign is_palindrome = !overflow_seen && !mismatch;
  assign kept_length   = apc_pkg::KEPT_W'(kept_count);
  assign overflow      = overflow_seen;

endmodule

`default_nettype wire

// ===== src/alnum_palindrome_checker_unit.sv =====
// Case-insensitive palindrome check over the ASCII letters and digits of a string.
//
// Input: one byte per beat on char_code, with last_char high on the final byte.
// A beat is taken at a rising edge where start is high and busy is low. Bytes
// that are not letters or digits are dropped; letters are folded to lower case.
// While a string loads, busy stays low and a byte can be taken every cycle.
//
// After the last byte, busy rises and the kept characters are compared in
// pairs from both ends, one pair per cycle through the two read ports of the
// character buffer. The result beat (done high for one cycle, with
// is_palindrome, kept_length and overflow) follows once every pair of the kept
// characters is compared; on overflow the sweep is skipped and the controller
// goes straight from compare to report. busy falls in the cycle after the result.
// The receiver cannot stall: the result is shown for exactly one cycle.
//
// Reset clears the count, overflow flag and controller; the buffer contents
// are not cleared and only positions written for the current string are read.
`default_nettype none

module alnum_palindrome_checker_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [apc_pkg::CHAR_W-1:0]  char_code,
  input  wire logic                        last_char,
  output logic                             busy,
  output logic                             done,
  output logic                             is_palindrome,
  output logic [apc_pkg::KEPT_W-1:0]       kept_length,
  output logic                             overflow
);

  apc_pkg::dp_cmd_t    cmd;
  apc_pkg::dp_status_t status;

  // Sequencing of load, compare and report.
  apc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_char (last_char),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  // Character buffer, count and pair compare.
  apc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .char_code     (char_code),
    .status        (status),
    .is_palindrome (is_palindrome),
    .kept_length   (kept_length),
    .overflow      (overflow)
  );

endmodule

`default_nettype wire
